/* src/pidaw_pkg.sv */
// Shared types, constants and saturation helpers for the PID controller block.
`timescale 1ns / 1ps
package pidaw_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_WIDTH   = VALUE_WIDTH + 16;
  localparam int MAG_WIDTH   = ACC_WIDTH - 1;
  localparam int DT_FRAC     = 24;
  localparam int CFG_IDX_W   = 3;

  localparam logic [ACC_WIDTH-1:0] ACC_LIM = {1'b0, {MAG_WIDTH{1'b1}}};
  localparam logic signed [ACC_WIDTH:0] ACC_LIM_X = {2'b00, {MAG_WIDTH{1'b1}}};
  localparam logic [VALUE_WIDTH-2:0] VAL_LIM = {(VALUE_WIDTH-1){1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILT_COEF   = 3'd5;

  // Item modes
  localparam logic [1:0] MODE_UPDATE    = 2'd0;
  localparam logic [1:0] MODE_CLR_INTEG = 2'd1;
  localparam logic [1:0] MODE_RESET     = 2'd2;

  typedef struct packed {
    logic [1:0]                    mode;
    logic signed [VALUE_WIDTH-1:0] err;
    logic [31:0]                   step_time;
  } pid_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] drive;
    logic                          saturated;
    logic                          integ_frozen;
    logic                          held;
  } pid_out_t;

  // Symmetric saturation of a grown sum to the accumulator range
  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [ACC_WIDTH:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > ACC_LIM_X) begin
      r = ACC_LIM;
    end else if (v < -ACC_LIM_X) begin
      r = -ACC_LIM;
    end else begin
      r = v[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [ACC_WIDTH-1:0] abs_acc(input logic signed [ACC_WIDTH-1:0] v);
    return v[ACC_WIDTH-1] ? ACC_WIDTH'(-v) : ACC_WIDTH'(v);
  endfunction

endpackage

/* src/pid_antiwindup_filtered_derivative.sv */
// Top level: configuration registers, step sequencer and controller state.
`timescale 1ns / 1ps
// Positional PID controller with conditional-integration anti-windup, an integral clamp and a
// low-pass filtered derivative. A clear-integral, full-reset, unused-mode or zero-step-time
// transaction passes from the dispatch state straight to the output state. An update
// transaction forms the derivative in the bit-serial divider, then makes five passes through
// the shared multiply unit (integral increment, derivative filter and the three gain terms
// share it in turn), with saturating adds between them. Without a previous error the divide
// and filter are skipped. One transaction is in work at a time; the input is ready again in
// the cycle in which the result is presented, and the result waits in an output register
// while the next one is accepted.
module pid_antiwindup_filtered_derivative (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pidaw_pkg::pid_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pidaw_pkg::pid_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import pidaw_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_INCR = 4'd2;
  localparam logic [3:0] S_CAND = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_FX   = 4'd5;
  localparam logic [3:0] S_FXS  = 4'd6;
  localparam logic [3:0] S_FMUL = 4'd7;
  localparam logic [3:0] S_DSAT = 4'd8;
  localparam logic [3:0] S_PMUL = 4'd9;
  localparam logic [3:0] S_IMUL = 4'd10;
  localparam logic [3:0] S_ISAT = 4'd11;
  localparam logic [3:0] S_DMUL = 4'd12;
  localparam logic [3:0] S_DSUM = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  // Configuration
  logic signed [31:0] prop_gain, integ_gain, deriv_gain;
  logic [30:0]        integ_limit, out_limit;
  logic [15:0]        filt_coef;

  // Controller state
  logic signed [ACC_WIDTH-1:0]   integ_acc, filt_deriv;
  logic signed [VALUE_WIDTH-1:0] prev_err, last_drive;
  logic                          prev_valid;

  // Working registers
  logic [3:0]                    state;
  logic [1:0]                    mode_val;
  logic signed [VALUE_WIDTH-1:0] err_val;
  logic [31:0]                   dt_val;
  logic signed [ACC_WIDTH:0]     wide_sum;
  logic signed [ACC_WIDTH-1:0]   cand, rd, deriv, raw;
  logic                          diff_neg;
  pid_out_t                      res;

  // Shared unit operands
  logic [31:0]                   mul_a;
  logic [ACC_WIDTH-1:0]          mul_b;
  logic                          mul_neg, mul_sh_dt, mul_go, mul_done;
  logic signed [ACC_WIDTH-1:0]   mul_res;
  logic [31:0]                   div_num;
  logic                          div_go, div_done;
  logic [MAG_WIDTH-1:0]          div_q;

  // Combinational helpers
  logic signed [VALUE_WIDTH-1:0] err_in;
  logic signed [ACC_WIDTH-1:0]   cand_sat, cand_clamp, ilim, fx_sat;
  logic signed [VALUE_WIDTH:0]   diff;
  logic [VALUE_WIDTH-1:0]        diff_mag;
  logic [ACC_WIDTH-1:0]          raw_mag;
  logic signed [ACC_WIDTH-1:0]   olim;
  logic                          fin_sat, fin_frozen;
  logic signed [VALUE_WIDTH-1:0] fin_drive;
  logic                          mul_start;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    err_in = (in_data.err == {1'b1, {(VALUE_WIDTH-1){1'b0}}}) ?
             -$signed({1'b0, VAL_LIM}) : in_data.err;
    cand_sat = sat_acc(wide_sum);
    ilim     = $signed(ACC_WIDTH'(integ_limit));
    cand_clamp = cand_sat;
    if (integ_limit != '0) begin
      if (cand_sat > ilim) cand_clamp = ilim;
      else if (cand_sat < -ilim) cand_clamp = -ilim;
    end
    diff     = (VALUE_WIDTH+1)'(err_val) - (VALUE_WIDTH+1)'(prev_err);
    diff_mag = diff[VALUE_WIDTH] ? VALUE_WIDTH'(-diff) : VALUE_WIDTH'(diff);
    fx_sat   = sat_acc(wide_sum);
    raw_mag  = abs_acc(raw);
    fin_sat  = (out_limit != '0) && (raw_mag > ACC_WIDTH'(out_limit));
    fin_frozen = fin_sat && ((err_val > 0 && raw > 0) || (err_val < 0 && raw < 0));
    olim = $signed(ACC_WIDTH'((out_limit != '0) ? out_limit : VAL_LIM));
    if (raw > olim) fin_drive = VALUE_WIDTH'(olim);
    else if (raw < -olim) fin_drive = VALUE_WIDTH'(-olim);
    else fin_drive = VALUE_WIDTH'(raw);
    // states that hand a new operand set to the multiply unit
    mul_start = ((state == S_DISP) && (mode_val == MODE_UPDATE) && (dt_val != '0)) ||
                ((state == S_CAND) && !prev_valid) ||
                (state == S_FXS) || (state == S_DSAT) ||
                ((state == S_PMUL) && mul_done) || (state == S_ISAT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_limit <= '0;
      out_limit   <= '0;
      filt_coef   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROP_GAIN:   prop_gain   <= cfg_data;
        CFG_INTEG_GAIN:  integ_gain  <= cfg_data;
        CFG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        CFG_INTEG_LIMIT: integ_limit <= cfg_data[30:0];
        CFG_OUT_LIMIT:   out_limit   <= cfg_data[30:0];
        CFG_FILT_COEF:   filt_coef   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_go <= !rst && mul_start;
    div_go <= !rst && (state == S_CAND) && prev_valid;
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      integ_acc  <= '0;
      filt_deriv <= '0;
      prev_err   <= '0;
      last_drive <= '0;
      prev_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_val <= in_data.mode;
            err_val  <= err_in;
            dt_val   <= in_data.step_time;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          res   <= '{drive: (mode_val == MODE_RESET) ? {VALUE_WIDTH{1'b0}} : last_drive,
                     saturated: 1'b0, integ_frozen: 1'b0,
                     held: (mode_val == MODE_UPDATE) && (dt_val == '0)};
          state <= S_OUT;
          case (mode_val)
            MODE_CLR_INTEG: integ_acc <= '0;
            MODE_RESET: begin
              integ_acc  <= '0;
              filt_deriv <= '0;
              prev_err   <= '0;
              last_drive <= '0;
              prev_valid <= 1'b0;
            end
            MODE_UPDATE: begin
              if (dt_val != '0) begin
                mul_a     <= err_val[VALUE_WIDTH-1] ? 32'(-err_val) : 32'(err_val);
                mul_b     <= ACC_WIDTH'(dt_val);
                mul_neg   <= err_val[VALUE_WIDTH-1];
                mul_sh_dt <= 1'b1;
                state     <= S_INCR;
              end
            end
            default: ;
          endcase
        end
        S_INCR: begin
          if (mul_done) begin
            wide_sum <= (ACC_WIDTH+1)'(integ_acc) + (ACC_WIDTH+1)'(mul_res);
            state    <= S_CAND;
          end
        end
        S_CAND: begin
          cand <= cand_clamp;
          if (prev_valid) begin
            div_num  <= diff_mag;
            diff_neg <= diff[VALUE_WIDTH];
            state    <= S_DIV;
          end else begin
            deriv     <= '0;
            mul_a     <= prop_gain[31] ? 32'(-prop_gain) : 32'(prop_gain);
            mul_b     <= err_val[VALUE_WIDTH-1] ? ACC_WIDTH'(-err_val) : ACC_WIDTH'(err_val);
            mul_neg   <= prop_gain[31] ^ err_val[VALUE_WIDTH-1];
            mul_sh_dt <= 1'b0;
            state     <= S_PMUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rd    <= diff_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            state <= S_FX;
          end
        end
        S_FX: begin
          wide_sum <= (ACC_WIDTH+1)'(filt_deriv) - (ACC_WIDTH+1)'(rd);
          state    <= S_FXS;
        end
        S_FXS: begin
          mul_a     <= 32'(filt_coef);
          mul_b     <= abs_acc(fx_sat);
          mul_neg   <= fx_sat[ACC_WIDTH-1];
          mul_sh_dt <= 1'b0;
          state     <= S_FMUL;
        end
        S_FMUL: begin
          if (mul_done) begin
            wide_sum <= (ACC_WIDTH+1)'(rd) + (ACC_WIDTH+1)'(mul_res);
            state    <= S_DSAT;
          end
        end
        S_DSAT: begin
          deriv     <= sat_acc(wide_sum);
          mul_a     <= prop_gain[31] ? 32'(-prop_gain) : 32'(prop_gain);
          mul_b     <= err_val[VALUE_WIDTH-1] ? ACC_WIDTH'(-err_val) : ACC_WIDTH'(err_val);
          mul_neg   <= prop_gain[31] ^ err_val[VALUE_WIDTH-1];
          mul_sh_dt <= 1'b0;
          state     <= S_PMUL;
        end
        S_PMUL: begin
          if (mul_done) begin
            raw     <= mul_res;
            mul_a   <= integ_gain[31] ? 32'(-integ_gain) : 32'(integ_gain);
            mul_b   <= abs_acc(cand);
            mul_neg <= integ_gain[31] ^ cand[ACC_WIDTH-1];
            state   <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mul_done) begin
            wide_sum <= (ACC_WIDTH+1)'(raw) + (ACC_WIDTH+1)'(mul_res);
            state    <= S_ISAT;
          end
        end
        S_ISAT: begin
          raw     <= sat_acc(wide_sum);
          mul_a   <= deriv_gain[31] ? 32'(-deriv_gain) : 32'(deriv_gain);
          mul_b   <= abs_acc(deriv);
          mul_neg <= deriv_gain[31] ^ deriv[ACC_WIDTH-1];
          state   <= S_DMUL;
        end
        S_DMUL: begin
          if (mul_done) begin
            wide_sum <= (ACC_WIDTH+1)'(raw) + (ACC_WIDTH+1)'(mul_res);
            state    <= S_DSUM;
          end
        end
        S_DSUM: begin
          raw   <= sat_acc(wide_sum);
          state <= S_FIN;
        end
        S_FIN: begin
          filt_deriv <= deriv;
          prev_err   <= err_val;
          prev_valid <= 1'b1;
          last_drive <= fin_drive;
          if (!fin_frozen) integ_acc <= cand;
          res   <= '{drive: fin_drive, saturated: fin_sat, integ_frozen: fin_frozen, held: 1'b0};
          state <= S_OUT;
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pidaw_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .go    (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .neg   (mul_neg),
    .sh_dt (mul_sh_dt),
    .res   (mul_res),
    .done  (mul_done)
  );

  pidaw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .go    (div_go),
    .num   (div_num),
    .den   (dt_val),
    .q_mag (div_q),
    .done  (div_done)
  );

  a_frozen_needs_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.integ_frozen || out_data.saturated))
    else $error("integral frozen without output saturation");

  a_held_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.held |-> !out_data.saturated && !out_data.integ_frozen)
    else $error("held result carries saturation flags");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DISP)
    else $error("accepted transaction did not start the sequencer");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mul_go |-> !div_go)
    else $error("multiplier and divider started together");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

endmodule

/* src/pidaw_mul.sv */
// Shared multiply unit: 32 x 48 magnitude product in two 32 x 32 passes, rounded and saturated.
`timescale 1ns / 1ps
module pidaw_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [31:0]                     a,
  input  logic [pidaw_pkg::ACC_WIDTH-1:0] b,
  input  logic                            neg,
  input  logic                            sh_dt,
  output logic signed [pidaw_pkg::ACC_WIDTH-1:0] res,
  output logic                            done
);
  import pidaw_pkg::*;

  localparam int PROD_W = 32 + ACC_WIDTH;
  localparam int SHF_W  = PROD_W - FRAC_BITS;
  localparam logic [PROD_W-1:0] RND_DT   = PROD_W'(1) << (DT_FRAC - 1);
  localparam logic [PROD_W-1:0] RND_FRAC = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LO   = 3'd1;
  localparam logic [2:0] PH_HI   = 3'd2;
  localparam logic [2:0] PH_RND  = 3'd3;
  localparam logic [2:0] PH_SAT  = 3'd4;

  logic [2:0]        phase;
  logic [PROD_W-1:0] prod;
  logic [SHF_W-1:0]  shifted;
  logic [31:0]       b_part;
  logic [63:0]       pp;
  logic [PROD_W-1:0] rnd;
  logic [MAG_WIDTH-1:0] mag;

  always_comb begin
    b_part = (phase == PH_LO) ? b[31:0] : 32'(b[ACC_WIDTH-1:32]);
    pp     = 64'(a) * 64'(b_part);
    rnd    = prod + (sh_dt ? RND_DT : RND_FRAC);
    mag    = (|shifted[SHF_W-1:MAG_WIDTH]) ? ACC_LIM[MAG_WIDTH-1:0] : shifted[MAG_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    done <= !rst && (phase == PH_SAT);
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (go) phase <= PH_LO;
        end
        PH_LO: begin
          prod  <= PROD_W'(pp);
          phase <= PH_HI;
        end
        PH_HI: begin
          prod  <= prod + (PROD_W'(pp) << 32);
          phase <= PH_RND;
        end
        PH_RND: begin
          shifted <= sh_dt ? SHF_W'(rnd >> DT_FRAC) : SHF_W'(rnd >> FRAC_BITS);
          phase   <= PH_SAT;
        end
        PH_SAT: begin
          res   <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          phase <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

/* src/pidaw_div.sv */
// Restoring divider, one quotient bit per cycle, for the derivative (diff << 24) / dt.
`timescale 1ns / 1ps
module pidaw_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [31:0]                     num,
  input  logic [31:0]                     den,
  output logic [pidaw_pkg::MAG_WIDTH-1:0] q_mag,
  output logic                            done
);
  import pidaw_pkg::*;

  localparam int NUM_W = 32 + DT_FRAC;

  logic [NUM_W-1:0] work;
  logic [31:0]      rem;
  logic [5:0]       cnt;
  logic [32:0]      trial;
  logic             fits;

  always_comb begin
    trial = {rem, work[NUM_W-1]};
    fits  = trial >= {1'b0, den};
    q_mag = (|work[NUM_W-1:MAG_WIDTH]) ? ACC_LIM[MAG_WIDTH-1:0] : work[MAG_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    done <= !rst && !go && (cnt == 6'd1);
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      work <= {num, {DT_FRAC{1'b0}}};
      rem  <= '0;
      cnt  <= 6'(NUM_W);
    end else if (cnt != '0) begin
      rem  <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
      work <= {work[NUM_W-2:0], fits};
      cnt  <= cnt - 6'd1;
    end
  end

endmodule

/* sim/pid_antiwindup_filtered_derivative_tb.sv */
// Testbench for the PID controller with anti-windup and filtered derivative.
`timescale 1ns / 1ps
module pid_antiwindup_filtered_derivative_tb;
  import pidaw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 120;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  pid_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  pid_out_t    out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pid_antiwindup_filtered_derivative dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller shadow: gains, limits and loop state
  longint kp, ki, kd, i_lim, o_lim, f_coef;
  longint integ, last_err, filt, last_out;
  bit     have_err;

  pid_out_t pending_out[$];
  int       errors;
  int       cycles;
  bit       calm;
  int       hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pid_antiwindup_filtered_derivative_tb NOT OK");
      $finish;
    end
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // round half away from zero of a*b / 2^sh, then clip to +-lim
  function automatic longint mul_round(longint a, longint b, int sh, longint lim);
    logic [127:0] p;
    logic [63:0]  ua, ub;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic pid_out_t control_step(pid_in_t it);
    pid_out_t   r;
    longint     e, incr, cand, deriv, diff, rd, raw, lim;
    logic [63:0] dt, md, q;
    e = clip(longint'($signed(it.err)), VAL_MAX);
    dt = {32'd0, it.step_time};
    r = '0;
    r.drive = last_out[31:0];
    if (it.mode == MODE_CLR_INTEG) begin
      integ = 0;
    end else if (it.mode == MODE_RESET) begin
      integ = 0; last_err = 0; filt = 0; last_out = 0; have_err = 0;
      r.drive = '0;
    end else if (it.mode == MODE_UPDATE && dt == 0) begin
      r.held = 1'b1;
    end else if (it.mode == MODE_UPDATE) begin
      incr = mul_round(e, longint'(dt), DT_FRAC, ACC_MAX);
      cand = clip(integ + incr, ACC_MAX);
      if (i_lim > 0) cand = clip(cand, i_lim);
      deriv = 0;
      if (have_err) begin
        diff = e - last_err;
        md = (diff < 0) ? -diff : diff;
        q = (md << DT_FRAC) / dt;
        rd = (q > ACC_MAX) ? ACC_MAX : longint'(q);
        if (diff < 0) rd = -rd;
        deriv = clip(rd + mul_round(f_coef, clip(filt - rd, ACC_MAX), 16, ACC_MAX),
                     ACC_MAX);
      end
      filt = deriv;
      last_err = e;
      have_err = 1;
      raw = mul_round(kp, e, FRAC_BITS, ACC_MAX);
      raw = clip(raw + mul_round(ki, cand, FRAC_BITS, ACC_MAX), ACC_MAX);
      raw = clip(raw + mul_round(kd, deriv, FRAC_BITS, ACC_MAX), ACC_MAX);
      r.saturated = (o_lim > 0) && (((raw < 0) ? -raw : raw) > o_lim);
      r.integ_frozen = r.saturated && ((e > 0 && raw > 0) || (e < 0 && raw < 0));
      if (!r.integ_frozen) integ = cand;
      lim = (o_lim > 0 && o_lim < VAL_MAX) ? o_lim : VAL_MAX;
      last_out = clip(raw, lim);
      r.drive = last_out[31:0];
    end
    return r;
  endfunction

  // result side: random stalls outside calm phases, plus a long hold-off on request
  always @(posedge clk) begin
    static int hold_left = 0;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 27);
    end
  end

  // both handshake signals are stable at the falling edge
  always @(negedge clk) begin
    pid_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result drive=%h", $realtime, out_data.drive);
        errors++;
      end else begin
        want = pending_out.pop_front();
        if (out_data.drive !== want.drive) begin
          $display("%0t: drive exp %h got %h", $realtime, want.drive, out_data.drive);
          errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated exp %b got %b", $realtime, want.saturated,
                   out_data.saturated);
          errors++;
        end
        if (out_data.integ_frozen !== want.integ_frozen) begin
          $display("%0t: integ_frozen exp %b got %b", $realtime, want.integ_frozen,
                   out_data.integ_frozen);
          errors++;
        end
        if (out_data.held !== want.held) begin
          $display("%0t: held exp %b got %b", $realtime, want.held, out_data.held);
          errors++;
        end
      end
    end
  end

  // offer one transaction and hold it until accepted
  task automatic send_step(logic [1:0] mode, logic [31:0] err, logic [31:0] dt);
    pid_in_t it;
    int gap;
    it.mode = mode;
    it.err = err;
    it.step_time = dt;
    gap = (!calm && $urandom_range(99) < 27) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      if (in_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_out.push_back(control_step(it));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] il, logic [31:0] ol, logic [31:0] c);
    logic [31:0] vals[6];
    vals = '{p, i, d, il, ol, c};
    drain_results();
    for (int k = 0; k < 6; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= k[2:0];
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    kp = longint'($signed(p));
    ki = longint'($signed(i));
    kd = longint'($signed(d));
    i_lim = longint'(il & 32'h7FFF_FFFF);
    o_lim = longint'(ol & 32'h7FFF_FFFF);
    f_coef = longint'(c & 32'h0000_FFFF);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(524288)) - 262144);
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(32'h0100_0000, 32'h0001_0000);
    endcase
  endfunction

  task automatic random_step(longint base);
    int sel;
    logic [1:0]  mode;
    logic [31:0] err, dt;
    sel = $urandom_range(99);
    mode = (sel < 86) ? MODE_UPDATE : (sel < 91) ? MODE_CLR_INTEG :
           (sel < 96) ? MODE_RESET : MODE_UNUSED;
    case ($urandom_range(3))
      0: err = $urandom;
      default: err = 32'(base + $signed($urandom_range(131072)) - 65536);
    endcase
    case ($urandom_range(9))
      0: dt = 32'd0;
      1: dt = $urandom;
      2: dt = $urandom_range(16);
      default: dt = $urandom_range(1677722, 16777);
    endcase
    send_step(mode, err, dt);
  endtask

  task automatic test_directed();
    send_step(MODE_UPDATE, 32'h7FFF_FFFF, 32'd1);
    load_regs(32'd65536, 32'd32768, 32'd655, 32'd6553600, 32'd3276800, 32'd32768);
    send_step(MODE_UPDATE, 32'd65536, 32'd167772);
    send_step(MODE_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_step(MODE_UPDATE, 32'h8000_0000, 32'd1);
    send_step(MODE_UPDATE, 32'd0, 32'd0);
    send_step(MODE_UPDATE, 32'hFFFF_FFFF, 32'd1);
    send_step(MODE_CLR_INTEG, 32'd12345, 32'd777);
    send_step(MODE_UPDATE, 32'd6553600, 32'd167772);
    send_step(MODE_UNUSED, 32'h8000_0000, 32'hFFFF_FFFF);
    send_step(MODE_RESET, 32'h7FFF_FFFF, 32'd5);
    send_step(MODE_UPDATE, 32'd327680, 32'd167772);
    send_step(MODE_UPDATE, 32'hFFFB_0000, 32'd16777);
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h0000_FFFF);
    send_step(MODE_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_step(MODE_UPDATE, 32'h8000_0000, 32'd1);
    send_step(MODE_UPDATE, 32'h7FFF_FFFF, 32'd1);
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
    send_step(MODE_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
    send_step(MODE_UPDATE, 32'h7FFF_FFFF, 32'd1);
    send_step(MODE_UPDATE, 32'd0, 32'h0100_0000);
    load_regs(32'd131072, 32'd65536, 32'd0, 32'd65536, 32'd1, 32'd1);
    send_step(MODE_UPDATE, 32'd655360, 32'd1677722);
    send_step(MODE_UPDATE, 32'hFFF6_0000, 32'd1677722);
  endtask

  task automatic test_random_phases();
    longint base;
    for (int ph = 0; ph < 8; ph++) begin
      load_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                $urandom_range(65535));
      calm = (ph == 3);
      base = $signed($urandom_range(1310720)) - 655360;
      repeat (220) begin
        random_step(base);
        base = base + $signed($urandom_range(8192)) - 4096;
      end
      calm = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    hold_req = 600;
    repeat (12) random_step(0);
  endtask

  task automatic test_drain_pause();
    repeat (10) random_step(65536);
    drain_results();
    repeat (10) random_step(-65536);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    out_ready <= 1'b0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_req = 0;
    kp = 0; ki = 0; kd = 0; i_lim = 0; o_lim = 0; f_coef = 0;
    integ = 0; last_err = 0; filt = 0; last_out = 0; have_err = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("pid_antiwindup_filtered_derivative_tb OK");
    end else begin
      $display("pid_antiwindup_filtered_derivative_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pidaw_pkg.sv
src/pidaw_mul.sv
src/pidaw_div.sv
src/pid_antiwindup_filtered_derivative.sv
sim/pid_antiwindup_filtered_derivative_tb.sv
